// File: rtl/lmssd_pkg.sv
// Shared types and constants of the LED matrix serial scan driver.
`default_nettype none

package lmssd_pkg;

    // Matrix geometry.
    localparam int unsigned MATRIX_ROWS = 8;
    localparam int unsigned ROW_W       = $clog2(MATRIX_ROWS);
    localparam int unsigned BYTE_W      = 8;

    // Command byte layout.
    localparam int unsigned BLOCK_START_BIT = 7;
    localparam int unsigned DOT_ON_BIT      = 6;
    localparam int unsigned DOT_ROW_LSB     = 3;
    localparam int unsigned DOT_COL_LSB     = 0;

    // Input item kinds carried on s_tuser.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [ROW_W-1:0]  row_t;

    // One result item.
    typedef struct packed {
        logic  echo_valid;
        byte_t echo_byte;
        byte_t row_select_n;
        byte_t column_drive_n;
    } result_t;

endpackage : lmssd_pkg

`default_nettype wire

// File: rtl/lmssd_core.sv
// Frame store, scan row and block-mode state, with the result of each accepted item.
`default_nettype none

module lmssd_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             op,
    input  wire lmssd_pkg::byte_t rx_byte,
    output lmssd_pkg::result_t    result
);
    import lmssd_pkg::*;

    byte_t frame_reg  [MATRIX_ROWS];
    byte_t frame_next [MATRIX_ROWS];
    row_t  scan_row_reg;
    row_t  scan_row_next;
    logic  block_active_reg;
    logic  block_active_next;
    row_t  block_row_reg;
    row_t  block_row_next;

    logic  is_byte;
    row_t  dot_row;
    row_t  dot_col;
    byte_t dot_mask;

    assign is_byte  = accept && (op == OP_BYTE);
    assign dot_row  = rx_byte[DOT_ROW_LSB +: ROW_W];
    assign dot_col  = rx_byte[DOT_COL_LSB +: ROW_W];
    assign dot_mask = byte_t'(1) << dot_col;

    // Each frame row decides its own next value from the command.
    always_comb
    begin
        for (int i = 0; i < MATRIX_ROWS; i++)
        begin
            frame_next[i] = frame_reg[i];
            if (is_byte)
            begin
                if (block_active_reg)
                begin
                    if (block_row_reg == row_t'(i))
                    begin
                        frame_next[i] = rx_byte;
                    end
                end
                else if (!rx_byte[BLOCK_START_BIT] && (dot_row == row_t'(i)))
                begin
                    if (rx_byte[DOT_ON_BIT])
                    begin
                        frame_next[i] = frame_reg[i] | dot_mask;
                    end
                    else
                    begin
                        frame_next[i] = frame_reg[i] & ~dot_mask;
                    end
                end
            end
        end
    end

    // Block-mode sequencing and scan row advance.
    always_comb
    begin
        block_active_next = block_active_reg;
        block_row_next    = block_row_reg;
        scan_row_next     = scan_row_reg;
        if (accept && (op == OP_TICK))
        begin
            scan_row_next = scan_row_reg + row_t'(1);
        end
        if (is_byte)
        begin
            if (block_active_reg)
            begin
                if (block_row_reg == row_t'(MATRIX_ROWS - 1))
                begin
                    block_active_next = 1'b0;
                    block_row_next    = '0;
                end
                else
                begin
                    block_row_next = block_row_reg + row_t'(1);
                end
            end
            else if (rx_byte[BLOCK_START_BIT])
            begin
                block_active_next = 1'b1;
                block_row_next    = '0;
            end
        end
    end

    // Result shows the state as it stands after this item.
    always_comb
    begin
        result.echo_valid     = (op == OP_BYTE);
        result.echo_byte      = (op == OP_BYTE) ? rx_byte : '0;
        result.row_select_n   = ~(byte_t'(1) << scan_row_next);
        result.column_drive_n = ~frame_next[scan_row_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MATRIX_ROWS; i++)
            begin
                frame_reg[i] <= '0;
            end
            scan_row_reg     <= '0;
            block_active_reg <= 1'b0;
            block_row_reg    <= '0;
        end
        else
        begin
            for (int i = 0; i < MATRIX_ROWS; i++)
            begin
                frame_reg[i] <= frame_next[i];
            end
            scan_row_reg     <= scan_row_next;
            block_active_reg <= block_active_next;
            block_row_reg    <= block_row_next;
        end
    end

endmodule : lmssd_core

`default_nettype wire

// File: rtl/led_matrix_serial_scan_driver.sv
// Top level of the LED matrix serial scan driver: state core plus output register and skid stage.
//
//  Channel | Direction | Handshake          | Payload
//  s_*     | in        | s_tvalid/s_tready  | tdata: rx_byte; tuser: op (1 = scan tick)
//  m_*     | out       | m_tvalid/m_tready  | tdata: echo_byte, row_select_n, column_drive_n;
//          |           |                    | tuser: echo_valid
//
// One item is accepted per clock while s_tready is high; its result is registered onto m_*.
// The frame row update and the scan row read are one pass of logic before the result register.
// Reset clears the frame store, scan row and block mode at once; no sweep follows reset.
// When m_tready is low, one more item is taken into the skid stage; s_tready then drops
// until the output side drains.
`default_nettype none

module led_matrix_serial_scan_driver
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] echo_byte, [15:8] row_select_n,
                                        // [23:16] column_drive_n
    output logic             m_tuser    // [0] echo_valid
);
    import lmssd_pkg::*;

    result_t new_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    s_xfer;
    logic    m_xfer;

    assign s_tready = !skid_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    lmssd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (s_xfer),
        .op      (s_tuser),
        .rx_byte (s_tdata),
        .result  (new_result)
    );

    // Output register valid flags; the skid stage fills only while the output is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_xfer)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= s_xfer;
            end
        end
        else if (s_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_xfer)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (s_xfer)
            begin
                out_reg <= new_result;
            end
        end
        else if (s_xfer)
        begin
            skid_reg <= new_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.echo_valid;
    assign m_tdata  = {out_reg.column_drive_n, out_reg.row_select_n, out_reg.echo_byte};

`ifndef ASSERT_OFF
    // The skid stage only holds an item behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // Exactly one row is driven low in every result.
    a_row_one_cold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(~m_tdata[15:8]))
        else $error("row select is not one-cold");

    // A scan tick carries no echo byte.
    a_tick_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0))
        else $error("echo byte nonzero on a tick result");

    // A transfer into a free output slot shows up as a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (!out_valid_reg || m_xfer)) |=> m_tvalid)
        else $error("accepted item produced no result");
`endif

endmodule : led_matrix_serial_scan_driver

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the LED matrix serial scan driver stream interface.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lmssd_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 10;

    // Tracks the frame store, scan row and block-mode state, and queues the
    // display output expected for every accepted input transfer.
    class matrix_frame_predictor;
        byte_t       frame_rows [MATRIX_ROWS];
        row_t        scan_row;
        bit          block_active;
        row_t        block_row;
        result_t     pending_outputs [$];
        int unsigned error_count;

        function new();
            foreach (frame_rows[i])
                frame_rows[i] = '0;
            scan_row     = '0;
            block_active = 1'b0;
            block_row    = '0;
            error_count  = 0;
        endfunction

        function int unsigned pending();
            return pending_outputs.size();
        endfunction

        // Apply one accepted input and queue the output it must produce.
        function void take_input(logic op, byte_t rx);
            result_t predicted;
            if (op == OP_TICK)
            begin
                scan_row             = scan_row + row_t'(1);
                predicted.echo_valid = 1'b0;
                predicted.echo_byte  = '0;
            end
            else
            begin
                if (block_active)
                begin
                    // In block mode every byte is a whole row, even one with the top bit set.
                    frame_rows[block_row] = rx;
                    if (block_row == row_t'(MATRIX_ROWS - 1))
                    begin
                        block_active = 1'b0;
                        block_row    = '0;
                    end
                    else
                        block_row = block_row + row_t'(1);
                end
                else if (rx[BLOCK_START_BIT])
                begin
                    block_active = 1'b1;
                    block_row    = '0;
                end
                else
                    frame_rows[rx[DOT_ROW_LSB +: ROW_W]][rx[DOT_COL_LSB +: ROW_W]] = rx[DOT_ON_BIT];
                predicted.echo_valid = 1'b1;
                predicted.echo_byte  = rx;
            end
            // The display outputs reflect the state after this update.
            predicted.row_select_n   = ~(byte_t'(1) << scan_row);
            predicted.column_drive_n = ~frame_rows[scan_row];
            pending_outputs.push_back(predicted);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        // Check one output transfer against the oldest prediction.
        function void check_output(result_t got);
            result_t want;
            if (pending_outputs.size() == 0)
            begin
                $error("output transfer with no prediction pending");
                error_count++;
                return;
            end
            want = pending_outputs.pop_front();
            compare_field("echo_valid", 32'(want.echo_valid), 32'(got.echo_valid));
            compare_field("echo_byte", 32'(want.echo_byte), 32'(got.echo_byte));
            compare_field("row_select_n", 32'(want.row_select_n), 32'(got.row_select_n));
            compare_field("column_drive_n", 32'(want.column_drive_n),
                          32'(got.column_drive_n));
        endfunction
    endclass

    typedef enum int unsigned
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_ONE_IN_FOUR,
        READY_SPARSE
    } stall_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    matrix_frame_predictor board;
    result_t               observed;
    bit                    hold_request   = 1'b0;
    int unsigned           burst_left     = 0;
    int unsigned           items_offered  = 0;
    int unsigned           cycle_count    = 0;

    led_matrix_serial_scan_driver DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Observe both channels at the rising edge; inputs are noted before outputs are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.take_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                observed.echo_valid     = m_tuser;
                observed.echo_byte      = m_tdata[7:0];
                observed.row_select_n   = m_tdata[15:8];
                observed.column_drive_n = m_tdata[23:16];
                board.check_output(observed);
            end
        end
    end

    // Receiver: switches between stall patterns, with an occasional long hold-off on request.
    initial
    begin
        stall_mode_t mode;
        int unsigned mode_left;
        int unsigned pattern_count;
        logic        ready;
        mode          = READY_ALWAYS;
        mode_left     = 0;
        pattern_count = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            pattern_count++;
            case (mode)
                READY_ALWAYS:      ready = 1'b1;
                READY_RANDOM:      ready = 1'($urandom_range(0, 1));
                READY_ONE_IN_FOUR: ready = (pattern_count % 4) == 0;
                default:           ready = $urandom_range(0, 7) == 0;
            endcase
            m_tready <= ready;
        end
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Present one item from a falling edge and hold it until the transfer completes.
    task automatic drive_item(logic op, byte_t rx);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_offered++;
    endtask

    task automatic idle_cycles(int unsigned count);
        if (count != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (count) @(negedge clk);
        end
    endtask

    // Sender side: items go out in bursts of random length separated by random gaps.
    task automatic offer(logic op, byte_t rx);
        if (burst_left == 0)
        begin
            idle_cycles($urandom_range(0, 8));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        drive_item(op, rx);
    endtask

    task automatic wait_outputs_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed dot commands, ticks and block loads, plus random noise bytes.
    task automatic send_random_commands(int unsigned count);
        int unsigned start;
        int unsigned pick;
        start = items_offered;
        while (items_offered - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                offer(OP_TICK, byte_t'($urandom));
            else if (pick < 70)
                offer(OP_BYTE, byte_t'($urandom) & 8'h7F);
            else if (pick < 85)
            begin
                offer(OP_BYTE, byte_t'($urandom) | 8'h80);
                repeat (MATRIX_ROWS)
                begin
                    if ($urandom_range(0, 5) == 0)
                        offer(OP_TICK, byte_t'($urandom));
                    offer(OP_BYTE, byte_t'($urandom));
                end
            end
            else
                offer(logic'($urandom_range(0, 1)), byte_t'($urandom));
        end
    endtask

    // Main sequence.
    initial
    begin
        board = new();
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: dot set and clear at the corners, a full scan wrap, then a block load.
        drive_item(OP_BYTE, 8'h40);
        drive_item(OP_BYTE, 8'h7F);
        drive_item(OP_BYTE, 8'h00);
        repeat (MATRIX_ROWS - 1) drive_item(OP_TICK, 8'hFF);
        drive_item(OP_TICK, 8'h00);
        drive_item(OP_BYTE, 8'h80);
        // The second row byte has the block-start bit set and must be stored as data.
        drive_item(OP_BYTE, 8'hFF);
        drive_item(OP_BYTE, 8'h80);
        drive_item(OP_BYTE, 8'h00);
        drive_item(OP_BYTE, 8'hA5);
        drive_item(OP_BYTE, 8'h5A);
        drive_item(OP_BYTE, 8'h81);
        drive_item(OP_BYTE, 8'h01);
        drive_item(OP_BYTE, 8'hC3);
        // Block mode has ended, so this is a dot clear on the last row and column.
        drive_item(OP_BYTE, 8'h3F);
        drive_item(OP_TICK, 8'h00);
        wait_outputs_drained();

        // Random phases; the second one runs against a long receiver hold-off.
        send_random_commands(300);
        wait_outputs_drained();
        hold_request = 1'b1;
        send_random_commands(300);
        wait_outputs_drained();
        send_random_commands(300);
        wait_outputs_drained();
        send_random_commands(200);
        wait_outputs_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.error_count == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/lmssd_pkg.sv
rtl/lmssd_core.sv
rtl/led_matrix_serial_scan_driver.sv
test/tb_top.sv
